// File: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset
`define WME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define WME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/wme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wme_pkg
// Types, codes and defaults for the watchpoint match and event queue block.
// ----------------------------------------------------------------------------
package wme_pkg;

    localparam int MAX_HOOKS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int DRAIN_LIMIT     = 64;

    localparam logic [2:0] CMD_REG    = 3'd0;
    localparam logic [2:0] CMD_UNREG  = 3'd1;
    localparam logic [2:0] CMD_ACCESS = 3'd2;
    localparam logic [2:0] CMD_DRAIN  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] RK_REG   = 2'd0;
    localparam logic [1:0] RK_UNREG = 2'd1;
    localparam logic [1:0] RK_EVENT = 2'd2;
    localparam logic [1:0] RK_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] val;
        logic [31:0] vmask;
        logic [31:0] xval;
        logic [31:0] xmask;
        logic [15:0] handle;
        logic [2:0]  kind;
        logic [3:0]  cpu;
    } hook_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] val;
        logic [31:0] frame;
        logic [15:0] handle;
        logic [2:0]  kind;
        logic [3:0]  cpu;
    } event_t;

endpackage

// File: design/wme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wme_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/watchpoint_match_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchpoint_match_event_queue
// Watch hook table and trace event queue, both held in block RAM.
// ----------------------------------------------------------------------------
// Register and empty drain reply on the cycle after start; clear gives no reply.
// Access: one hook read and compared per cycle.
// Unregister: scans until the handle is found or the table ends; later hooks move down one a cycle.
// Drain of n events: one event per cycle off the queue RAM port.
// Reset clears state, counters and pointers (handle counter restarts at 1); RAM contents are not cleared.
module watchpoint_match_event_queue #(
    parameter int MAX_HOOKS   = wme_pkg::MAX_HOOKS_DEF,
    parameter int QUEUE_DEPTH = wme_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  access_kind,
    input  logic [3:0]  cpu_id,
    input  logic [31:0] address,
    input  logic [31:0] end_address,
    input  logic [31:0] data_value,
    input  logic [31:0] value_mask,
    input  logic [31:0] extra_value,
    input  logic [31:0] extra_mask,
    input  logic [15:0] hook_handle,
    input  logic [31:0] frame_number,
    input  logic [6:0]  max_count,
    output logic        strobe,
    output logic [1:0]  result_kind,
    output logic        ok,
    output logic [15:0] out_handle,
    output logic [31:0] event_address,
    output logic [31:0] event_value,
    output logic [31:0] event_frame,
    output logic [2:0]  event_kind,
    output logic [3:0]  event_cpu,
    output logic [31:0] dropped_count,
    output logic        last
);

    localparam int IW = (MAX_HOOKS > 1) ? $clog2(MAX_HOOKS) : 1;
    localparam int CW = $clog2(MAX_HOOKS + 1);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = (FW > 7) ? FW : 7;

    wme_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [15:0]    hctr_reg, hctr_next;
    logic [QW-1:0]  head_reg, head_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [31:0]    drop_reg, drop_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [6:0]     rem_reg, rem_next;
    logic [2:0]     cmd_reg, cmd_next;
    wme_pkg::event_t acc_reg, acc_next;
    logic [31:0]    frame_reg, frame_next;

    logic           strobe_reg, strobe_next;
    logic [1:0]     rk_reg, rk_next;
    logic           ok_reg, ok_next;
    logic           last_reg, last_next;
    wme_pkg::event_t ev_reg, ev_next;
    logic [31:0]    dout_reg, dout_next;

    logic            h_we;
    logic [IW-1:0]   h_waddr, h_raddr;
    wme_pkg::hook_t  h_wdata, h_rdata;
    logic            q_we;
    logic [QW-1:0]   q_waddr, q_raddr;
    wme_pkg::event_t q_wdata, q_rdata;

    wme_ram #(.WIDTH($bits(wme_pkg::hook_t)), .DEPTH(MAX_HOOKS)) u_hook_ram (
        .clk  (clk),
        .we   (h_we),
        .waddr(h_waddr),
        .wdata(h_wdata),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    wme_ram #(.WIDTH($bits(wme_pkg::event_t)), .DEPTH(QUEUE_DEPTH)) u_event_ram (
        .clk  (clk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    // shared conditions
    logic           tbl_full, found, hit, scan_last, shift_last, q_full, drain_last;
    logic [CW-1:0]  idx_inc;
    logic [CW:0]    idx_inc2;
    logic [6:0]     clamp, drain_n;
    logic [FW:0]    slot_sum;
    logic [QW-1:0]  slot, head_inc;

    assign tbl_full   = count_reg >= CW'(MAX_HOOKS);
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_inc2   = {1'b0, idx_reg} + 2'd2;
    assign scan_last  = idx_inc >= count_reg;
    assign shift_last = idx_inc2 >= {1'b0, count_reg};
    assign found      = (cmd_reg == wme_pkg::CMD_UNREG) && (h_rdata.handle == acc_reg.handle);
    assign hit        = (cmd_reg == wme_pkg::CMD_ACCESS)
                      && (h_rdata.kind == acc_reg.kind) && (h_rdata.cpu == acc_reg.cpu)
                      && (acc_reg.addr >= h_rdata.lo) && (acc_reg.addr <= h_rdata.hi)
                      && ((acc_reg.val & h_rdata.vmask) == (h_rdata.val & h_rdata.vmask))
                      && ((acc_reg.frame & h_rdata.xmask) == (h_rdata.xval & h_rdata.xmask));
    assign drain_last = rem_reg == 7'd1;

    always_comb
    begin
        if (max_count == 7'd0)
        begin
            clamp = 7'd1;
        end
        else if (max_count > 7'(wme_pkg::DRAIN_LIMIT))
        begin
            clamp = 7'(wme_pkg::DRAIN_LIMIT);
        end
        else
        begin
            clamp = max_count;
        end
        drain_n = (NW'(fill_reg) < NW'(clamp)) ? 7'(fill_reg) : clamp;
    end

    // queue write slot; when full this lands on the head, i.e. the dropped entry
    assign q_full   = fill_reg == FW'(QUEUE_DEPTH);
    assign slot_sum = (FW + 1)'(head_reg) + (FW + 1)'(fill_reg);
    assign slot     = (slot_sum >= (FW + 1)'(QUEUE_DEPTH))
                    ? QW'(slot_sum - (FW + 1)'(QUEUE_DEPTH)) : QW'(slot_sum);
    assign head_inc = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wme_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        wme_pkg::CMD_UNREG, wme_pkg::CMD_ACCESS:
                            if (count_reg != '0) state_next = wme_pkg::ST_SCAN;
                        wme_pkg::CMD_DRAIN:
                            if (fill_reg != '0) state_next = wme_pkg::ST_DRAIN;
                        default:
                            state_next = wme_pkg::ST_IDLE;
                    endcase
                end
            end
            wme_pkg::ST_SCAN:
            begin
                if (found)
                begin
                    state_next = scan_last ? wme_pkg::ST_IDLE : wme_pkg::ST_SHIFT;
                end
                else if (scan_last)
                begin
                    state_next = wme_pkg::ST_IDLE;
                end
            end
            wme_pkg::ST_SHIFT:
            begin
                if (shift_last) state_next = wme_pkg::ST_IDLE;
            end
            wme_pkg::ST_DRAIN:
            begin
                if (drain_last) state_next = wme_pkg::ST_IDLE;
            end
            default:
                state_next = wme_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory control and result register
    always_comb
    begin
        count_next  = count_reg;
        hctr_next   = hctr_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        cmd_next    = cmd_reg;
        acc_next    = acc_reg;
        frame_next  = frame_reg;
        strobe_next = 1'b0;
        rk_next     = wme_pkg::RK_REG;
        ok_next     = 1'b0;
        last_next   = 1'b0;
        ev_next     = '0;
        dout_next   = drop_reg;

        h_we    = 1'b0;
        h_waddr = count_reg[IW-1:0];
        h_wdata = '0;
        h_raddr = '0;
        q_we    = 1'b0;
        q_waddr = slot;
        q_wdata = acc_reg;
        q_raddr = head_reg;

        case (state_reg)
            wme_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    acc_next.addr   = address;
                    acc_next.val    = data_value;
                    acc_next.frame  = extra_value;   // extra value held here during a scan
                    acc_next.handle = hook_handle;
                    acc_next.kind   = access_kind;
                    acc_next.cpu    = cpu_id;
                    frame_next      = frame_number;
                    case (cmd)
                        wme_pkg::CMD_REG:
                        begin
                            strobe_next = 1'b1;
                            rk_next     = wme_pkg::RK_REG;
                            if (!tbl_full)
                            begin
                                h_we           = 1'b1;
                                h_wdata.lo     = address;
                                h_wdata.hi     = end_address;
                                h_wdata.val    = data_value;
                                h_wdata.vmask  = value_mask;
                                h_wdata.xval   = extra_value;
                                h_wdata.xmask  = extra_mask;
                                h_wdata.handle = hctr_reg;
                                h_wdata.kind   = access_kind;
                                h_wdata.cpu    = cpu_id;
                                count_next     = count_reg + 1'b1;
                                hctr_next      = hctr_reg + 16'd1;
                                ok_next        = 1'b1;
                                ev_next.handle = hctr_reg;
                            end
                        end
                        wme_pkg::CMD_UNREG:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                rk_next     = wme_pkg::RK_UNREG;
                            end
                        end
                        wme_pkg::CMD_DRAIN:
                        begin
                            rem_next = drain_n;
                            if (fill_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                rk_next     = wme_pkg::RK_EMPTY;
                                last_next   = 1'b1;
                            end
                        end
                        wme_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                            fill_next  = '0;
                            drop_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            wme_pkg::ST_SCAN:
            begin
                // next entry is fetched while this one is compared
                h_raddr  = idx_inc[IW-1:0];
                idx_next = idx_inc;
                if (found)
                begin
                    if (scan_last)
                    begin
                        count_next  = count_reg - 1'b1;
                        strobe_next = 1'b1;
                        rk_next     = wme_pkg::RK_UNREG;
                        ok_next     = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg;
                    end
                end
                else if ((cmd_reg == wme_pkg::CMD_UNREG) && scan_last)
                begin
                    strobe_next = 1'b1;
                    rk_next     = wme_pkg::RK_UNREG;
                end
                if (hit)
                begin
                    q_we           = 1'b1;
                    q_wdata.frame  = frame_reg;
                    q_wdata.handle = h_rdata.handle;
                    if (q_full)
                    begin
                        head_next = head_inc;
                        if (drop_reg != '1) drop_next = drop_reg + 32'd1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            wme_pkg::ST_SHIFT:
            begin
                // rdata holds entry idx+1; move it down one place
                h_we     = 1'b1;
                h_waddr  = idx_reg[IW-1:0];
                h_wdata  = h_rdata;
                h_raddr  = idx_inc2[IW-1:0];
                idx_next = idx_inc;
                if (shift_last)
                begin
                    count_next  = count_reg - 1'b1;
                    strobe_next = 1'b1;
                    rk_next     = wme_pkg::RK_UNREG;
                    ok_next     = 1'b1;
                end
            end
            wme_pkg::ST_DRAIN:
            begin
                q_raddr     = head_inc;
                head_next   = head_inc;
                fill_next   = fill_reg - 1'b1;
                rem_next    = rem_reg - 7'd1;
                strobe_next = 1'b1;
                rk_next     = wme_pkg::RK_EVENT;
                ok_next     = 1'b1;
                ev_next     = q_rdata;
                last_next   = drain_last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wme_pkg::ST_IDLE;
            count_reg  <= '0;
            hctr_reg   <= 16'd1;
            head_reg   <= '0;
            fill_reg   <= '0;
            drop_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            hctr_reg   <= hctr_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            strobe_reg <= strobe_next;
        end
    end

    // The frame field of a stored event is rewritten on push, so the
    // scan latch reuses it for the access extra value.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        cmd_reg   <= cmd_next;
        acc_reg   <= acc_next;
        frame_reg <= frame_next;
        rk_reg    <= rk_next;
        ok_reg    <= ok_next;
        last_reg  <= last_next;
        ev_reg    <= ev_next;
        dout_reg  <= dout_next;
    end

    assign busy          = state_reg != wme_pkg::ST_IDLE;
    assign strobe        = strobe_reg;
    assign result_kind   = rk_reg;
    assign ok            = ok_reg;
    assign out_handle    = ev_reg.handle;
    assign event_address = ev_reg.addr;
    assign event_value   = ev_reg.val;
    assign event_frame   = ev_reg.frame;
    assign event_kind    = ev_reg.kind;
    assign event_cpu     = ev_reg.cpu;
    assign dropped_count = dout_reg;
    assign last          = last_reg;

endmodule

// File: design/wme_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wme_chk
// Port-level checks for the watchpoint block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wme_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  cmd,
    input logic        strobe,
    input logic [1:0]  result_kind,
    input logic        ok,
    input logic [15:0] out_handle,
    input logic        last
);

    `WME_ASSERT_NEXT(a_reg_reply, clk, rst_n,
        start && !busy && cmd == wme_pkg::CMD_REG,
        strobe && result_kind == wme_pkg::RK_REG)
    `WME_ASSERT_NOW(a_empty_last, clk, rst_n,
        strobe && result_kind == wme_pkg::RK_EMPTY, last && !ok)
    `WME_ASSERT_NOW(a_fail_handle, clk, rst_n,
        strobe && result_kind == wme_pkg::RK_REG && !ok, out_handle == 16'd0)
    `WME_ASSERT_NOW(a_event_ok, clk, rst_n,
        strobe && result_kind == wme_pkg::RK_EVENT, ok)

endmodule

bind watchpoint_match_event_queue wme_chk u_wme_chk (.*);

// File: test/tb_watchpoint_match_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_watchpoint_match_event_queue
// Directed table, a table fill and queue flood, then random traffic. Hook registration, removal, memory
// accesses and drains are predicted in the bench and every reply and drained
// event is checked field by field. Start gaps are random.
// ----------------------------------------------------------------------------
module tb_watchpoint_match_event_queue;

    localparam int NHOOK  = wme_pkg::MAX_HOOKS_DEF;
    localparam int QDEPTH = wme_pkg::QUEUE_DEPTH_DEF;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic        ok;
        logic [15:0] handle;
        logic [31:0] addr;
        logic [31:0] val;
        logic [31:0] frame;
        logic [2:0]  akind;
        logic [3:0]  cpu;
        logic [31:0] dropped;
        logic        last;
    } reply_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  kind;
        logic [3:0]  cpu;
        logic [31:0] addr;
        logic [31:0] eaddr;
        logic [31:0] val;
        logic [31:0] vmask;
        logic [31:0] xval;
        logic [31:0] xmask;
        logic [15:0] handle;
        logic [31:0] frame;
        logic [6:0]  maxc;
    } txn_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0]  cmd = '0;
    logic [2:0]  access_kind = '0;
    logic [3:0]  cpu_id = '0;
    logic [31:0] address = '0, end_address = '0, data_value = '0, value_mask = '0;
    logic [31:0] extra_value = '0, extra_mask = '0, frame_number = '0;
    logic [15:0] hook_handle = '0;
    logic [6:0]  max_count = '0;
    logic        strobe;
    logic [1:0]  result_kind;
    logic        ok, last;
    logic [15:0] out_handle;
    logic [31:0] event_address, event_value, event_frame, dropped_count;
    logic [2:0]  event_kind;
    logic [3:0]  event_cpu;

    watchpoint_match_event_queue dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    wme_pkg::hook_t  hooks[NHOOK];
    int              nhooks = 0;
    logic [15:0]     handle_ctr = 16'd1;
    wme_pkg::event_t evq[$];
    logic [31:0]     drops = '0;

    reply_t expected_replies[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_txn = 0, n_replies = 0, n_events = 0;

    function automatic void exp_put(input reply_t r);
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    function automatic reply_t mk(logic [1:0] k, logic o, logic [15:0] h, logic l);
        reply_t r;
        r = '{k, o, h, '0, '0, '0, '0, '0, drops, l};
        return r;
    endfunction

    task automatic predict(input txn_t t);
        reply_t r;
        int n;
        int i;
        bit found;
        wme_pkg::event_t e;
        case (t.cmd)
            wme_pkg::CMD_REG:
                if (nhooks >= NHOOK) exp_put(mk(wme_pkg::RK_REG, 1'b0, 16'd0, 1'b0));
                else
                begin
                    hooks[nhooks] = '{t.addr, t.eaddr, t.val, t.vmask, t.xval, t.xmask,
                                      handle_ctr, t.kind, t.cpu};
                    nhooks++;
                    exp_put(mk(wme_pkg::RK_REG, 1'b1, handle_ctr, 1'b0));
                    handle_ctr++;
                end
            wme_pkg::CMD_UNREG:
            begin
                found = 0;
                for (i = 0; i < nhooks; i++)
                begin
                    if (!found && hooks[i].handle == t.handle) found = 1;
                    if (found && i + 1 < nhooks) hooks[i] = hooks[i + 1];
                end
                if (found) nhooks--;
                exp_put(mk(wme_pkg::RK_UNREG, found, 16'd0, 1'b0));
            end
            wme_pkg::CMD_ACCESS:
                for (i = 0; i < nhooks; i++)
                begin
                    if (hooks[i].kind != t.kind || hooks[i].cpu != t.cpu) continue;
                    if (t.addr < hooks[i].lo || t.addr > hooks[i].hi) continue;
                    if (((t.val ^ hooks[i].val) & hooks[i].vmask) != 0) continue;
                    if (((t.xval ^ hooks[i].xval) & hooks[i].xmask) != 0) continue;
                    if (evq.size() >= QDEPTH)
                    begin
                        evq.delete(0);
                        if (drops != 32'hFFFF_FFFF) drops++;
                    end
                    e = '{t.addr, t.val, t.frame, hooks[i].handle, t.kind, t.cpu};
                    evq.insert(evq.size(), e);
                end
            wme_pkg::CMD_DRAIN:
            begin
                n = t.maxc == 0 ? 1
                  : (t.maxc > wme_pkg::DRAIN_LIMIT ? wme_pkg::DRAIN_LIMIT : t.maxc);
                if (evq.size() == 0) exp_put(mk(wme_pkg::RK_EMPTY, 1'b0, 16'd0, 1'b1));
                else
                begin
                    if (evq.size() < n) n = evq.size();
                    for (i = 0; i < n; i++)
                    begin
                        e = evq[0];
                        evq.delete(0);
                        r = '{wme_pkg::RK_EVENT, 1'b1, e.handle, e.addr, e.val, e.frame,
                              e.kind, e.cpu, drops, (i + 1 == n)};
                        exp_put(r);
                    end
                end
            end
            wme_pkg::CMD_CLEAR:
            begin
                nhooks = 0;
                evq.delete();
                drops = '0;
            end
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        reply_t x;
        if (rst_n && strobe)
        begin
            n_replies++;
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result kind %0d", result_kind);
                errors++;
            end
            else
            begin
                x = expected_replies[0];
                expected_replies.delete(0);
                if (x.kind == wme_pkg::RK_EVENT) n_events++;
                if (result_kind !== x.kind)
                begin $error("result_kind exp %0d got %0d", x.kind, result_kind); errors++; end
                if (ok !== x.ok)
                begin $error("ok exp %0d got %0d", x.ok, ok); errors++; end
                if (out_handle !== x.handle)
                begin $error("out_handle exp %h got %h", x.handle, out_handle); errors++; end
                if (event_address !== x.addr)
                begin $error("event_address exp %h got %h", x.addr, event_address); errors++; end
                if (event_value !== x.val)
                begin $error("event_value exp %h got %h", x.val, event_value); errors++; end
                if (event_frame !== x.frame)
                begin $error("event_frame exp %h got %h", x.frame, event_frame); errors++; end
                if (event_kind !== x.akind)
                begin $error("event_kind exp %0d got %0d", x.akind, event_kind); errors++; end
                if (event_cpu !== x.cpu)
                begin $error("event_cpu exp %0d got %0d", x.cpu, event_cpu); errors++; end
                if (dropped_count !== x.dropped)
                begin
                    $error("dropped_count exp %0d got %0d", x.dropped, dropped_count);
                    errors++;
                end
                if (last !== x.last)
                begin $error("last exp %0d got %0d", x.last, last); errors++; end
            end
        end
    end

    // watchdog on cycles with no transaction of either kind
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    // start stays high into a back-to-back transaction and drops only for a gap
    task automatic send(input txn_t t);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= t.cmd; access_kind <= t.kind; cpu_id <= t.cpu; address <= t.addr;
        end_address <= t.eaddr; data_value <= t.val; value_mask <= t.vmask;
        extra_value <= t.xval; extra_mask <= t.xmask; hook_handle <= t.handle;
        frame_number <= t.frame; max_count <= t.maxc;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict(t);
        n_txn++;
    endtask

    function automatic txn_t rnd_txn(input bit wide);
        txn_t t;
        t.cmd = 3'($urandom_range(0, 2));
        case ($urandom_range(0, 19))
            0, 1, 2:     t.cmd = wme_pkg::CMD_REG;
            3, 4:        t.cmd = wme_pkg::CMD_UNREG;
            5, 6, 7, 8, 9, 10, 11, 12: t.cmd = wme_pkg::CMD_ACCESS;
            13, 14, 15:  t.cmd = wme_pkg::CMD_DRAIN;
            16:          t.cmd = wme_pkg::CMD_CLEAR;
            17:          t.cmd = 3'($urandom_range(5, 7));
            default:     t.cmd = wme_pkg::CMD_ACCESS;
        endcase
        // narrow fields so accesses often hit registered hooks
        t.kind = wide ? 3'($urandom) : 3'($urandom_range(0, 1));
        t.cpu = wide ? 4'($urandom) : 4'($urandom_range(0, 1));
        t.addr = wide ? $urandom : $urandom_range(0, 255);
        t.eaddr = wide ? $urandom : t.addr + $urandom_range(0, 200);
        t.val = $urandom;
        t.vmask = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom_range(0, 1) ? 32'hF : 32'h0);
        t.xval = $urandom;
        t.xmask = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom_range(0, 1) ? 32'h3 : 32'h0);
        t.handle = wide ? 16'($urandom) : handle_ctr - 16'($urandom_range(1, 20));
        t.frame = $urandom;
        t.maxc = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
        return t;
    endfunction

    txn_t directed[$];

    initial
    begin
        txn_t t;
        int i;
        int settle;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, expected reply kinds typed in for the first two rows
        directed = '{
            '{wme_pkg::CMD_DRAIN,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd0},
            '{wme_pkg::CMD_UNREG,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd1, 32'd0, 7'd1},
            '{wme_pkg::CMD_REG,    3'd7, 4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
              32'd0, 16'd0, 32'd0, 7'd1},
            '{wme_pkg::CMD_REG,    3'd7, 4'd15, 32'h10, 32'h8, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd1},
            '{wme_pkg::CMD_REG,    3'd7, 4'd15, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 32'd0, 7'd1},
            '{wme_pkg::CMD_ACCESS, 3'd7, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0,
              32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 7'd0},
            '{wme_pkg::CMD_ACCESS, 3'd7, 4'd15, 32'h12, 32'd0, 32'h0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'h5, 7'd0},
            '{wme_pkg::CMD_ACCESS, 3'd0, 4'd0, 32'h12, 32'd0, 32'h0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'h6, 7'd0},
            '{3'd5,                3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd0},
            '{wme_pkg::CMD_DRAIN,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd1},
            '{wme_pkg::CMD_DRAIN,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd127},
            '{wme_pkg::CMD_UNREG,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd2, 32'd0, 7'd1},
            '{wme_pkg::CMD_UNREG,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'hFFFF, 32'd0, 7'd1},
            '{wme_pkg::CMD_CLEAR,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd1},
            '{3'd7,                3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd1},
            '{wme_pkg::CMD_DRAIN,  3'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 32'd0, 7'd64}
        };
        foreach (directed[k])
        begin
            send(directed[k]);
            // first two rows have fixed replies that the predictor must agree with
            if (k < 2 && expected_replies.size() > 0 &&
                expected_replies[$].kind !== (k == 0 ? wme_pkg::RK_EMPTY : wme_pkg::RK_UNREG))
            begin
                $error("result_kind exp %0d got %0d",
                       k == 0 ? wme_pkg::RK_EMPTY : wme_pkg::RK_UNREG,
                       expected_replies[$].kind);
                errors++;
            end
        end

        // fill table past full, then flood the queue to force drops
        for (i = 0; i < NHOOK + 2; i++)
        begin
            t = '{wme_pkg::CMD_REG, 3'd1, 4'd2, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                  32'd0, 16'd0, 32'd0, 7'd1};
            send(t);
        end
        for (i = 0; i < 6; i++)
        begin
            t = rnd_txn(0);
            t.cmd = wme_pkg::CMD_ACCESS; t.kind = 3'd1; t.cpu = 4'd2; t.frame = i;
            send(t);
        end
        t.cmd = wme_pkg::CMD_DRAIN; t.maxc = 7'd64;
        send(t);
        send(t);
        t.cmd = wme_pkg::CMD_CLEAR;
        send(t);

        // handles keep rising across a clear
        for (i = 0; i < 4; i++)
        begin
            t.cmd = wme_pkg::CMD_REG; send(t);
            t.cmd = wme_pkg::CMD_CLEAR; send(t);
        end

        for (i = 0; i < 70; i++)
        begin
            t = rnd_txn($urandom_range(0, 4) == 0);
            send(t);
        end
        t.cmd = wme_pkg::CMD_DRAIN; t.maxc = 7'd64;
        send(t);
        start <= 1'b0;

        settle = 0;
        while (expected_replies.size() != 0 && settle < WATCHDOG)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (80) @(posedge clk);
        $display("covered %0d transactions, %0d results of which %0d drained events",
                 n_txn, n_replies, n_events);
        if (errors == 0 && expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
